/* src/ir_tx_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir_tx_pkg
// Shared types and constants for the pulse-distance infrared transmitter.
// ----------------------------------------------------------------------------
package ir_tx_pkg;

   localparam int FRAME_BITS  = 32;
   localparam int BITS_DONE_W = 6;
   localparam int TICK_W      = 13;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 12;

   localparam logic [CSR_INDEX_W-1:0] REG_ADDRESS_HIGH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_ADDRESS_LOW   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_LEADER_BURST  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_LEADER_SPACE  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_BIT_BURST     = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] REG_ONE_SPACE_MUL = 3'd5;

   localparam logic [7:0]  RST_ADDRESS_HIGH  = 8'h81;
   localparam logic [7:0]  RST_ADDRESS_LOW   = 8'h66;
   localparam logic [11:0] RST_LEADER_BURST  = 12'd684;
   localparam logic [11:0] RST_LEADER_SPACE  = 12'd342;
   localparam logic [7:0]  RST_BIT_BURST     = 8'd42;
   localparam logic [2:0]  RST_ONE_SPACE_MUL = 3'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LEADER,
      PH_DATA,
      PH_END
   } phase_type;

   typedef struct packed {
      logic [7:0]  address_high;
      logic [7:0]  address_low;
      logic [11:0] leader_burst_ticks;
      logic [11:0] leader_space_ticks;
      logic [7:0]  bit_burst_ticks;
      logic [2:0]  one_space_multiplier;
   } cfg_type;

   typedef struct packed {
      logic       action;
      logic [7:0] command;
   } req_item_type;

   typedef struct packed {
      logic frame_done;
      logic accepted;
      logic busy_res;
      logic led_level;
   } rsp_item_type;

endpackage
`default_nettype wire

/* src/ir_tx_csr.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir_tx_csr
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module ir_tx_csr
   import ir_tx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            REG_ADDRESS_HIGH:  cfg_in.address_high         = csr_wdata[7:0];
            REG_ADDRESS_LOW:   cfg_in.address_low          = csr_wdata[7:0];
            REG_LEADER_BURST:  cfg_in.leader_burst_ticks   = csr_wdata[11:0];
            REG_LEADER_SPACE:  cfg_in.leader_space_ticks   = csr_wdata[11:0];
            REG_BIT_BURST:     cfg_in.bit_burst_ticks      = csr_wdata[7:0];
            REG_ONE_SPACE_MUL: cfg_in.one_space_multiplier = csr_wdata[2:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.address_high         <= RST_ADDRESS_HIGH;
         cfg_ff.address_low          <= RST_ADDRESS_LOW;
         cfg_ff.leader_burst_ticks   <= RST_LEADER_BURST;
         cfg_ff.leader_space_ticks   <= RST_LEADER_SPACE;
         cfg_ff.bit_burst_ticks      <= RST_BIT_BURST;
         cfg_ff.one_space_multiplier <= RST_ONE_SPACE_MUL;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

/* src/ir_tx_in_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir_tx_in_stage
// Input register for request beats.
// ----------------------------------------------------------------------------
module ir_tx_in_stage
   import ir_tx_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [7:0]   req_tdata,
   input  wire logic         req_tuser,
   input  wire logic         advance,
   output logic              item_valid,
   output req_item_type      item
);

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         take;

   assign req_tready = !valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff.action  <= req_tuser;
         item_ff.command <= req_tdata;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule
`default_nettype wire

/* src/ir_tx_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir_tx_core
// Frame sequencer: updates transmit state for one beat and forms its result.
// ----------------------------------------------------------------------------
module ir_tx_core
   import ir_tx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  cfg_type      cfg,
   input  wire logic    fire,
   input  req_item_type item,
   output rsp_item_type result
);

   phase_type              phase_ff, phase_in;
   logic [TICK_W-1:0]      tick_ff, tick_in;
   logic [BITS_DONE_W-1:0] bits_ff, bits_in;
   logic [31:0]            frame_ff, frame_in;
   logic                   led_ff, led_in;
   logic                   acc;
   logic                   done;

   logic [TICK_W:0]        tick_inc;
   logic [TICK_W:0]        leader_len;
   logic [BITS_DONE_W-1:0] bits_inc;
   logic                   cur_bit;
   logic [2:0]             mult;
   logic [3:0]             mult_p1;
   logic [11:0]            bit_len;
   logic                   in_burst;

   always_comb begin
      tick_inc   = {1'b0, tick_ff} + 14'd1;
      leader_len = {2'b0, cfg.leader_burst_ticks} + {2'b0, cfg.leader_space_ticks};
      bits_inc   = bits_ff + 6'd1;
      cur_bit    = frame_ff[5'd31 - bits_ff[4:0]];
      mult       = cur_bit ? cfg.one_space_multiplier : 3'd1;
      mult_p1    = {1'b0, mult} + 4'd1;
      bit_len    = {4'b0, cfg.bit_burst_ticks} * {8'b0, mult_p1};
      in_burst   = tick_ff < {5'b0, cfg.bit_burst_ticks};

      phase_in = phase_ff;
      tick_in  = tick_ff;
      bits_in  = bits_ff;
      frame_in = frame_ff;
      led_in   = led_ff;
      acc      = 1'b0;
      done     = 1'b0;

      if (item.action) begin
         if (phase_ff == PH_IDLE) begin
            frame_in = {cfg.address_high, cfg.address_low, item.command, ~item.command};
            phase_in = PH_LEADER;
            tick_in  = '0;
            bits_in  = '0;
            led_in   = 1'b0;
            acc      = 1'b1;
         end
      end else begin
         case (phase_ff)
            PH_IDLE: begin
               led_in = 1'b0;
            end
            PH_LEADER: begin
               led_in  = (tick_ff < {1'b0, cfg.leader_burst_ticks}) ? !led_ff : 1'b0;
               tick_in = tick_inc[TICK_W-1:0];
               if (tick_inc >= leader_len) begin
                  phase_in = PH_DATA;
                  tick_in  = '0;
                  bits_in  = '0;
                  led_in   = 1'b0;
               end
            end
            PH_DATA: begin
               led_in  = in_burst ? !led_ff : 1'b0;
               tick_in = tick_inc[TICK_W-1:0];
               if (tick_inc >= {2'b0, bit_len}) begin
                  tick_in = '0;
                  led_in  = 1'b0;
                  bits_in = bits_inc;
                  if (bits_inc >= BITS_DONE_W'(FRAME_BITS)) begin
                     phase_in = PH_END;
                  end
               end
            end
            PH_END: begin
               if (in_burst) begin
                  led_in  = !led_ff;
                  tick_in = tick_inc[TICK_W-1:0];
               end else begin
                  led_in   = 1'b0;
                  phase_in = PH_IDLE;
                  tick_in  = '0;
                  bits_in  = '0;
                  frame_in = '0;
                  done     = 1'b1;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               led_in   = 1'b0;
            end
         endcase
      end

      result.led_level  = led_in;
      result.busy_res   = phase_in != PH_IDLE;
      result.accepted   = acc;
      result.frame_done = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tick_ff  <= '0;
         bits_ff  <= '0;
         frame_ff <= '0;
         led_ff   <= 1'b0;
      end else if (fire) begin
         phase_ff <= phase_in;
         tick_ff  <= tick_in;
         bits_ff  <= bits_in;
         frame_ff <= frame_in;
         led_ff   <= led_in;
      end
   end

   a_accept_starts_leader: assert property (@(posedge clock) disable iff (reset)
      fire && result.accepted |=> phase_ff == PH_LEADER && tick_ff == '0)
      else $error("accepted request did not start leader");

   a_done_clears_frame: assert property (@(posedge clock) disable iff (reset)
      fire && result.frame_done |=> phase_ff == PH_IDLE && frame_ff == '0 && !led_ff)
      else $error("frame end did not return to idle");

   a_idle_led_off: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_IDLE |-> !led_ff)
      else $error("LED driven while idle");

   a_bits_bounded: assert property (@(posedge clock) disable iff (reset)
      bits_ff <= BITS_DONE_W'(FRAME_BITS))
      else $error("bit count past frame length");

   a_done_only_from_end: assert property (@(posedge clock) disable iff (reset)
      fire && result.frame_done |-> phase_ff == PH_END && !item.action)
      else $error("frame done outside end burst");

endmodule
`default_nettype wire

/* src/ir_tx_out_stage.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir_tx_out_stage
// Result register for response beats.
// ----------------------------------------------------------------------------
module ir_tx_out_stage
   import ir_tx_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    load,
   input  rsp_item_type result,
   output logic         load_ready,
   output logic         rsp_tvalid,
   input  wire logic    rsp_tready,
   output logic [7:0]   rsp_tdata
);

   logic         valid_ff;
   logic         valid_in;
   rsp_item_type data_ff;

   assign load_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {4'b0, data_ff};

endmodule
`default_nettype wire

/* src/ir_remote_pulse_distance_transmitter_unit.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// ir_remote_pulse_distance_transmitter_unit
// Pulse-distance infrared transmitter stepped by carrier ticks and send beats.
// ----------------------------------------------------------------------------
// Pipeline: input register, combinational sequencer, then output register.
// Throughput: one beat per cycle while rsp_tready holds; the sequencer state
// updates once per beat. Reset: synchronous; clears the sequencer to idle with
// the LED off and loads the default configuration registers.
module ir_remote_pulse_distance_transmitter_unit
   import ir_tx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] command
   input  wire logic                   req_tuser,   // [0] action
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   output logic [7:0]                  rsp_tdata,   // [0] led_level, [1] busy_res,
                                                    // [2] accepted, [3] frame_done
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type      cfg;
   req_item_type item;
   rsp_item_type result;
   logic         item_valid;
   logic         load_ready;
   logic         advance;

   assign advance = item_valid && load_ready;

   ir_tx_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ir_tx_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   ir_tx_core u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (advance),
      .item   (item),
      .result (result)
   );

   ir_tx_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (advance),
      .result     (result),
      .load_ready (load_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

/* bench/ir_tx_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ir_tx_checker
// Watches the request, response and register ports of the infrared
// transmitter, steps its own copy of the frame sequencer on every accepted
// request beat and compares each response beat against the oldest queued
// LED and status prediction.
// ----------------------------------------------------------------------------
module ir_tx_checker
   import ir_tx_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   input  wire logic                   req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] command
   input  wire logic                   req_tuser,   // [0] action
   input  wire logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   input  wire logic [7:0]             rsp_tdata,   // [0] led_level, [1] busy_res,
                                                    // [2] accepted, [3] frame_done
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                          mismatch_total,
   output int                          expected_left
);

   cfg_type                settings;
   phase_type              phase;
   logic [TICK_W-1:0]      tick_count;
   logic [BITS_DONE_W-1:0] bits_done;
   logic [31:0]            frame_word;
   logic                   led;
   rsp_item_type           led_status_queue[$];
   int                     responses_seen;

   task automatic step_transmitter(input logic send, input logic [7:0] command,
                                   output rsp_item_type status);
      int   count_next;
      int   seg_len;
      logic bit_value;
      status = '0;
      count_next = tick_count + 1;
      if (send) begin
         if (phase == PH_IDLE) begin
            frame_word = {settings.address_high, settings.address_low, command, ~command};
            phase = PH_LEADER;
            tick_count = '0;
            bits_done = '0;
            led = 1'b0;
            status.accepted = 1'b1;
         end
      end else begin
         case (phase)
            PH_LEADER: begin
               if (tick_count < settings.leader_burst_ticks) led = ~led;
               else led = 1'b0;
               tick_count = count_next[TICK_W-1:0];
               if (count_next >= settings.leader_burst_ticks + settings.leader_space_ticks) begin
                  phase = PH_DATA;
                  tick_count = '0;
                  bits_done = '0;
                  led = 1'b0;
               end
            end
            PH_DATA: begin
               bit_value = frame_word[31 - bits_done[4:0]];
               seg_len = settings.bit_burst_ticks *
                         (1 + (bit_value ? settings.one_space_multiplier : 1));
               if (tick_count < settings.bit_burst_ticks) led = ~led;
               else led = 1'b0;
               tick_count = count_next[TICK_W-1:0];
               if (count_next >= seg_len) begin
                  tick_count = '0;
                  led = 1'b0;
                  bits_done = bits_done + 1'b1;
                  if (bits_done >= FRAME_BITS) phase = PH_END;
               end
            end
            PH_END: begin
               if (tick_count < settings.bit_burst_ticks) begin
                  led = ~led;
                  tick_count = count_next[TICK_W-1:0];
               end else begin
                  led = 1'b0;
                  phase = PH_IDLE;
                  tick_count = '0;
                  bits_done = '0;
                  frame_word = '0;
                  status.frame_done = 1'b1;
               end
            end
            default: begin
               phase = PH_IDLE;
               led = 1'b0;
            end
         endcase
      end
      status.led_level = led;
      status.busy_res = (phase != PH_IDLE);
   endtask

   always @(posedge clock) begin
      rsp_item_type want;
      rsp_item_type seen;
      if (reset) begin
         settings.address_high = RST_ADDRESS_HIGH;
         settings.address_low = RST_ADDRESS_LOW;
         settings.leader_burst_ticks = RST_LEADER_BURST;
         settings.leader_space_ticks = RST_LEADER_SPACE;
         settings.bit_burst_ticks = RST_BIT_BURST;
         settings.one_space_multiplier = RST_ONE_SPACE_MUL;
         phase = PH_IDLE;
         tick_count = '0;
         bits_done = '0;
         frame_word = '0;
         led = 1'b0;
         led_status_queue.delete();
         responses_seen = 0;
         mismatch_total = 0;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_ADDRESS_HIGH:  settings.address_high = csr_wdata[7:0];
               REG_ADDRESS_LOW:   settings.address_low = csr_wdata[7:0];
               REG_LEADER_BURST:  settings.leader_burst_ticks = csr_wdata[11:0];
               REG_LEADER_SPACE:  settings.leader_space_ticks = csr_wdata[11:0];
               REG_BIT_BURST:     settings.bit_burst_ticks = csr_wdata[7:0];
               REG_ONE_SPACE_MUL: settings.one_space_multiplier = csr_wdata[2:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            step_transmitter(req_tuser, req_tdata, want);
            led_status_queue.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            seen = rsp_item_type'(rsp_tdata[3:0]);
            if (led_status_queue.size() == 0) begin
               if (mismatch_total < 10)
                  $display("%0t: response beat %b with nothing outstanding", $time, rsp_tdata);
               mismatch_total++;
            end else begin
               want = led_status_queue.pop_front();
               if (seen !== want) begin
                  if (mismatch_total < 10)
                     $display({"%0t: beat %0d expected led=%b busy=%b accepted=%b done=%b,",
                               " got led=%b busy=%b accepted=%b done=%b"},
                              $time, responses_seen, want.led_level, want.busy_res,
                              want.accepted, want.frame_done, seen.led_level, seen.busy_res,
                              seen.accepted, seen.frame_done);
                  mismatch_total++;
               end
            end
            responses_seen++;
         end
      end
      expected_left <= led_status_queue.size();
   end

endmodule

/* bench/tb_ir_remote_pulse_distance_transmitter_unit.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_remote_pulse_distance_transmitter_unit
// Drives tick and send beats into the infrared transmitter across a range of
// timing and address settings, from zero-length segments to the widest
// register values, with and without random stalls on both stream ports.
// The checker beside the block predicts every response beat.
// ----------------------------------------------------------------------------
module tb_ir_remote_pulse_distance_transmitter_unit;
   import ir_tx_pkg::*;

   localparam logic ACT_TICK       = 1'b0;
   localparam logic ACT_SEND       = 1'b1;
   localparam int   WATCHDOG_LIMIT = 2000;
   localparam int   RANDOM_QUOTA   = 150;
   localparam int   CUT_TICKS      = 60;

   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [7:0]             req_tdata  = '0;   // [7:0] command
   logic                   req_tuser  = 1'b0; // [0] action
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [7:0]             rsp_tdata;         // [0] led_level, [1] busy_res,
                                              // [2] accepted, [3] frame_done
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int      mismatch_total;
   int      expected_left;
   int      send_idle_pct = 0;
   int      rx_idle_pct   = 0;
   int      quiet_cycles  = 0;
   int      items_sent    = 0;
   int      ticks_left    = 0;
   cfg_type tx_cfg;

   ir_remote_pulse_distance_transmitter_unit uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   ir_tx_checker checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_total (mismatch_total),
      .expected_left  (expected_left)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // ticks from an accepted send beat until the frame is back to idle
   function automatic int frame_length_ticks(input logic [7:0] command);
      logic [31:0] word;
      int          span;
      int          total;
      word = {tx_cfg.address_high, tx_cfg.address_low, command, ~command};
      span = tx_cfg.leader_burst_ticks + tx_cfg.leader_space_ticks;
      total = (span == 0) ? 1 : span;
      for (int b = 0; b < FRAME_BITS; b++) begin
         span = tx_cfg.bit_burst_ticks *
                (1 + (word[31-b] ? tx_cfg.one_space_multiplier : 1));
         total += (span == 0) ? 1 : span;
      end
      return total + tx_cfg.bit_burst_ticks + 1;
   endfunction

   task automatic send_beat(input logic action, input logic [7:0] command);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= action;
      req_tdata <= command;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
   endtask

   task automatic begin_frame(input logic [7:0] command);
      send_beat(ACT_SEND, command);
      ticks_left = frame_length_ticks(command);
   endtask

   task automatic finish_frame();
      while (ticks_left > 0) begin
         send_beat(ACT_TICK, 8'($urandom_range(255)));
         ticks_left--;
      end
   endtask

   // drop valid and hold until every response beat has drained
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_left != 0);
   endtask

   task automatic write_reg(input logic [CSR_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
   endtask

   task automatic write_config(input logic [7:0] address_high, input logic [7:0] address_low,
                               input logic [11:0] leader_burst, input logic [11:0] leader_space,
                               input logic [7:0] bit_burst, input logic [2:0] one_space_mul);
      tx_cfg.address_high = address_high;
      tx_cfg.address_low = address_low;
      tx_cfg.leader_burst_ticks = leader_burst;
      tx_cfg.leader_space_ticks = leader_space;
      tx_cfg.bit_burst_ticks = bit_burst;
      tx_cfg.one_space_multiplier = one_space_mul;
      write_reg(REG_ADDRESS_HIGH, CSR_DATA_W'(address_high));
      write_reg(REG_ADDRESS_LOW, CSR_DATA_W'(address_low));
      write_reg(REG_LEADER_BURST, CSR_DATA_W'(leader_burst));
      write_reg(REG_LEADER_SPACE, CSR_DATA_W'(leader_space));
      write_reg(REG_BIT_BURST, CSR_DATA_W'(bit_burst));
      write_reg(REG_ONE_SPACE_MUL, CSR_DATA_W'(one_space_mul));
      csr_we <= 1'b0;
   endtask

   // run part of a long leader, then shorten the timings and finish the frame
   task automatic cut_frame(input logic [7:0] command, input int run_ticks);
      repeat (run_ticks) send_beat(ACT_TICK, 8'($urandom_range(255)));
      settle();
      write_config(tx_cfg.address_high, tx_cfg.address_low, 12'd1, 12'd1, 8'd1, 3'd1);
      ticks_left = frame_length_ticks(command);
      finish_frame();
   endtask

   // short random timings; mostly whole frames, some idle ticks and busy sends
   task automatic random_settings(input int quota);
      int         first_item;
      int         frames_wanted;
      int         frames_begun;
      logic [7:0] command;
      first_item = items_sent;
      while (items_sent - first_item < quota) begin
         settle();
         write_config(8'($urandom_range(255)), 8'($urandom_range(255)),
                      12'($urandom_range(6)), 12'($urandom_range(6)),
                      ($urandom_range(9) < 7) ? 8'd1 : 8'($urandom_range(3)),
                      3'($urandom_range(7)));
         frames_wanted = 1 + $urandom_range(2);
         frames_begun = 0;
         while (frames_begun < frames_wanted || ticks_left != 0) begin
            command = 8'($urandom_range(255));
            if (ticks_left == 0) begin
               if ($urandom_range(99) < 70) begin
                  begin_frame(command);
                  frames_begun++;
               end else begin
                  send_beat(ACT_TICK, command);
               end
            end else if ($urandom_range(99) < 6) begin
               send_beat(ACT_SEND, command);
            end else begin
               send_beat(ACT_TICK, command);
               ticks_left--;
            end
         end
      end
   endtask

   initial begin
      tx_cfg.address_high = RST_ADDRESS_HIGH;
      tx_cfg.address_low = RST_ADDRESS_LOW;
      tx_cfg.leader_burst_ticks = RST_LEADER_BURST;
      tx_cfg.leader_space_ticks = RST_LEADER_SPACE;
      tx_cfg.bit_burst_ticks = RST_BIT_BURST;
      tx_cfg.one_space_multiplier = RST_ONE_SPACE_MUL;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 25;
      rx_idle_pct = 86;
      send_beat(ACT_TICK, 8'hFF);
      send_beat(ACT_TICK, 8'h00);
      begin_frame(8'hA5);
      send_beat(ACT_SEND, 8'h5A);
      cut_frame(8'hA5, CUT_TICKS);

      // zero-length leader, bits and end burst
      settle();
      write_config(8'h00, 8'h00, 12'd0, 12'd0, 8'd0, 3'd0);
      begin_frame(8'h00);
      finish_frame();
      begin_frame(8'hFF);
      send_beat(ACT_SEND, 8'h00);
      finish_frame();

      // odd bursts, no leader or one-bit space, LED forced low at boundaries
      settle();
      write_config(8'hFF, 8'h00, 12'd3, 12'd0, 8'd3, 3'd0);
      begin_frame(8'h0F);
      finish_frame();

      settle();
      write_config(8'hAA, 8'h55, 12'd1, 12'd1, 8'd1, 3'd7);
      begin_frame(8'hF0);
      finish_frame();
      random_settings(RANDOM_QUOTA);

      send_idle_pct = 86;
      rx_idle_pct = 25;
      settle();
      write_config(8'hFF, 8'hFF, 12'd4095, 12'd1, 8'd1, 3'd7);
      begin_frame(8'hC3);
      cut_frame(8'hC3, CUT_TICKS);
      random_settings(RANDOM_QUOTA);

      send_idle_pct = 0;
      rx_idle_pct = 0;
      settle();
      write_config(8'h3C, 8'hFF, 12'd1, 12'd4095, 8'd2, 3'd1);
      begin_frame(8'h81);
      cut_frame(8'h81, CUT_TICKS);
      random_settings(RANDOM_QUOTA);

      settle();
      write_config(8'h00, 8'h00, 12'd4095, 12'd4095, 8'd255, 3'd7);
      begin_frame(8'hFF);
      cut_frame(8'hFF, CUT_TICKS);

      settle();
      repeat (4) @(posedge clock);
      if (mismatch_total == 0 && expected_left == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
